// ===== rtl/lzss_pkg.sv =====
// Shared types and constants for the LZSS halfword token compressor.
package lzss_pkg;

	localparam int MAX_MATCH   = 18;
	localparam int MIN_MATCH   = 3;
	localparam int BLOCK_CODES = 32;
	localparam int BLOCK_WORDS = BLOCK_CODES / 2;
	localparam int TQ_DEPTH    = 4;
	localparam logic [7:0] HDR_TAG = 8'hF0;
	localparam logic [31:0] FLAG_TOP = 32'h8000_0000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        last_word;
	} result_t;

	typedef enum logic [1:0] {
		TK_HDR,
		TK_CODE,
		TK_END
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic        final_step;
		logic        is_match;
		logic [23:0] data;
	} token_t;

	typedef struct packed {
		logic        is_match;
		logic [15:0] code;
		logic [4:0]  skip;
	} match_res_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_HDR,
		F_DECIDE,
		F_SEARCH,
		F_CODE,
		F_END
	} front_state_t;

	typedef enum logic {
		P_TAKE,
		P_EMIT
	} pack_state_t;

endpackage

// ===== rtl/lzss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lzss_match.sv =====
// Exhaustive window match search, one candidate position per cycle.
module lzss_match #(
	parameter int WINDOW_SIZE = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(WINDOW_SIZE)-1:0] r_pos,
	input  logic [4:0]                    avail,
	input  logic [7:0]                    hist [lzss_pkg::MAX_MATCH],
	input  logic [$clog2(WINDOW_SIZE):0]  wr_count,
	output logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
	input  logic [7:0]                    rd_data,
	output logic                          done,
	output lzss_pkg::match_res_t          res
);

	localparam int AW  = $clog2(WINDOW_SIZE);
	localparam int MM  = lzss_pkg::MAX_MATCH;
	localparam int FAR = WINDOW_SIZE - MM;
	localparam logic [AW-1:0] LAST_RD = AW'(WINDOW_SIZE - 2);

	logic          busy_q;
	logic          rd_act_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] base_q;
	logic          v_s1;
	logic          inval_s1;
	logic          cv_s2;
	logic [4:0]    nsh_q;
	logic [AW-1:0] d_q;
	logic [4:0]    best_q;
	logic [AW-1:0] bd_q;
	logic [4:0]    avail_q;
	logic          done_q;
	logic [7:0]    win_q [MM];
	logic [7:0]    la_q [MM];
	logic [MM-1:0] eq;
	logic [4:0]    len;
	logic [4:0]    idx [MM];

	assign rd_addr = base_q + rd_q;
	assign done    = done_q;

	always_comb begin
		for (int i = 0; i < MM; i++) begin
			eq[i]  = (win_q[i] == la_q[i]) && (5'(i) < avail_q);
			idx[i] = 5'(MM) - avail + 5'(i);
		end
		len = 5'(MM);
		for (int i = MM - 1; i >= 0; i--) begin
			if (!eq[i]) begin
				len = 5'(i);
			end
		end
	end

	always_comb begin
		if (best_q >= 5'(lzss_pkg::MIN_MATCH)) begin
			res.is_match = 1'b1;
			res.code     = {4'(best_q - 5'(lzss_pkg::MIN_MATCH)), 12'(bd_q - AW'(1))};
			res.skip     = best_q - 5'd1;
		end else begin
			res.is_match = 1'b0;
			res.code     = {(avail_q >= 5'd2) ? la_q[1] : 8'h00, la_q[0]};
			res.skip     = 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_act_q <= 1'b0;
			rd_q     <= '0;
			v_s1     <= 1'b0;
			cv_s2    <= 1'b0;
			nsh_q    <= '0;
			d_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				rd_act_q <= 1'b1;
				rd_q     <= '0;
				v_s1     <= 1'b0;
				cv_s2    <= 1'b0;
				nsh_q    <= '0;
				d_q      <= AW'(FAR);
			end else begin
				if (rd_act_q) begin
					rd_q <= rd_q + AW'(1);
					if (rd_q == LAST_RD) begin
						rd_act_q <= 1'b0;
					end
				end
				v_s1 <= rd_act_q;
				if (v_s1) begin
					nsh_q <= (nsh_q == 5'(MM)) ? nsh_q : nsh_q + 5'd1;
					cv_s2 <= (nsh_q >= 5'(MM - 1));
				end else begin
					cv_s2 <= 1'b0;
				end
				if (cv_s2) begin
					d_q <= d_q - AW'(1);
					if (d_q == AW'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_q  <= r_pos + AW'(MM);
			best_q  <= '0;
			bd_q    <= AW'(1);
			avail_q <= avail;
			for (int i = 0; i < MM; i++) begin
				la_q[i] <= (idx[i] < 5'(MM)) ? hist[idx[i]] : 8'h00;
			end
		end else begin
			inval_s1 <= !(wr_count[AW] || ({1'b0, rd_addr} < wr_count));
			if (v_s1) begin
				for (int i = 0; i < MM - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[MM-1] <= inval_s1 ? 8'hFF : rd_data;
			end
			if (cv_s2 && (len >= best_q)) begin
				best_q <= len;
				bd_q   <= d_q;
			end
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("match done without a search in progress");

endmodule

// ===== rtl/lzss_front.sv =====
// Front end: takes bytes, keeps the window, sequences positions and searches.
module lzss_front #(
	parameter int WINDOW_SIZE = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lzss_pkg::item_t     item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [23:0]         cfg_data,
	output logic                tok_push,
	input  logic                tok_ready,
	output lzss_pkg::token_t    tok
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int MM = lzss_pkg::MAX_MATCH;

	lzss_pkg::front_state_t state_q, state_d;
	logic [AW-1:0]        wp_q;
	logic [4:0]           fill_q;
	logic [AW:0]          wcnt_q;
	logic [4:0]           skip_q;
	logic                 hdr_q;
	logic                 last_q;
	logic [23:0]          total_q;
	logic [7:0]           hist_q [MM];
	lzss_pkg::match_res_t res_q;
	lzss_pkg::match_res_t mres;
	logic                 accept;
	logic                 mstart;
	logic                 mdone;
	logic                 do_skip;
	logic                 do_code;
	logic                 do_end;
	logic [AW-1:0]        rd_addr;
	logic [7:0]           rd_data;

	assign full      = (state_q != lzss_pkg::F_IDLE);
	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	lzss_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_win (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (item.data_byte),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	lzss_match #(.WINDOW_SIZE(WINDOW_SIZE)) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mstart),
		.r_pos    (wp_q - AW'(fill_q)),
		.avail    (fill_q),
		.hist     (hist_q),
		.wr_count (wcnt_q),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.done     (mdone),
		.res      (mres)
	);

	always_comb begin
		state_d  = state_q;
		tok_push = 1'b0;
		tok      = '0;
		mstart   = 1'b0;
		do_skip  = 1'b0;
		do_code  = 1'b0;
		do_end   = 1'b0;
		case (state_q)
			lzss_pkg::F_IDLE: begin
				if (accept) begin
					state_d = hdr_q ? lzss_pkg::F_DECIDE : lzss_pkg::F_HDR;
				end
			end
			lzss_pkg::F_HDR: begin
				tok.kind = lzss_pkg::TK_HDR;
				tok.data = total_q;
				tok_push = 1'b1;
				if (tok_ready) begin
					state_d = lzss_pkg::F_DECIDE;
				end
			end
			lzss_pkg::F_DECIDE: begin
				if (last_q ? (fill_q != 5'd0) : (fill_q >= 5'(MM))) begin
					if (skip_q != 5'd0) begin
						do_skip = 1'b1;
					end else begin
						mstart  = 1'b1;
						state_d = lzss_pkg::F_SEARCH;
					end
				end else begin
					state_d = last_q ? lzss_pkg::F_END : lzss_pkg::F_IDLE;
				end
			end
			lzss_pkg::F_SEARCH: begin
				if (mdone) begin
					state_d = lzss_pkg::F_CODE;
				end
			end
			lzss_pkg::F_CODE: begin
				tok.kind       = lzss_pkg::TK_CODE;
				tok.final_step = last_q;
				tok.is_match   = res_q.is_match;
				tok.data       = {8'h00, res_q.code};
				tok_push       = 1'b1;
				if (tok_ready) begin
					do_code = 1'b1;
					state_d = lzss_pkg::F_DECIDE;
				end
			end
			lzss_pkg::F_END: begin
				tok.kind = lzss_pkg::TK_END;
				tok_push = 1'b1;
				if (tok_ready) begin
					do_end  = 1'b1;
					state_d = lzss_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = lzss_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzss_pkg::F_IDLE;
			wp_q    <= '0;
			fill_q  <= '0;
			wcnt_q  <= '0;
			skip_q  <= '0;
			hdr_q   <= 1'b0;
			last_q  <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				total_q <= cfg_data;
			end
			if (accept) begin
				wp_q   <= wp_q + AW'(1);
				fill_q <= (fill_q < 5'(MM)) ? fill_q + 5'd1 : fill_q;
				wcnt_q <= wcnt_q[AW] ? wcnt_q : wcnt_q + {{AW{1'b0}}, 1'b1};
				last_q <= item.last_byte;
			end
			if ((state_q == lzss_pkg::F_HDR) && tok_ready) begin
				hdr_q <= 1'b1;
			end
			if (do_skip) begin
				skip_q <= skip_q - 5'd1;
				fill_q <= fill_q - 5'd1;
			end
			if (do_code) begin
				skip_q <= res_q.skip;
				fill_q <= fill_q - 5'd1;
			end
			if (do_end) begin
				wp_q   <= '0;
				fill_q <= '0;
				wcnt_q <= '0;
				skip_q <= '0;
				hdr_q  <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MM - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[MM-1] <= item.data_byte;
		end
		if (mdone) begin
			res_q <= mres;
		end
	end

endmodule

// ===== rtl/lzss_tq.sv =====
// Short token queue between the search front end and the block packer.
module lzss_tq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             ready,
	input  lzss_pkg::token_t din,
	output logic             valid,
	input  logic             pop,
	output lzss_pkg::token_t dout
);

	localparam int D  = lzss_pkg::TQ_DEPTH;
	localparam int PW = $clog2(D);

	lzss_pkg::token_t mem_q [D];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign ready   = (cnt_q < (PW+1)'(D));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(D))
		else $error("token queue count beyond depth");

endmodule

// ===== rtl/lzss_pack.sv =====
// Back end: gathers codes into blocks and emits header, flag and code words.
module lzss_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tq_valid,
	output logic              tq_pop,
	input  lzss_pkg::token_t  tk,
	output logic              empty,
	input  logic              pop,
	output lzss_pkg::result_t result
);

	localparam int BC = lzss_pkg::BLOCK_CODES;
	localparam int BW = lzss_pkg::BLOCK_WORDS;

	lzss_pkg::pack_state_t state_q, state_d;
	logic [31:0] flag_q;
	logic [15:0] lo_q [BW];
	logic [15:0] hi_q [BW];
	logic [5:0]  cnt_q;
	logic [4:0]  widx_q;
	logic        hold_q;
	logic        elast_q;
	logic        pend_q;
	logic [31:0] held_q;
	logic        ovld_q;
	logic [31:0] oword_q;
	logic        olast_q;

	logic        slot;
	logic        load;
	logic [31:0] lw;
	logic        ll;
	logic        take_code;
	logic        clr_blk;
	logic        set_pend;
	logic        clr_pend;
	logic        go_emit;
	logic        emit_hold;
	logic        emit_last;
	logic        widx_inc;
	logic [3:0]  j;
	logic        lo_ok;
	logic        hi_ok;

	assign slot   = !ovld_q || pop;
	assign empty  = !ovld_q;
	assign result = {oword_q, olast_q};
	assign j      = 4'(widx_q - 5'd1);
	assign lo_ok  = ({1'b0, j, 1'b0} < cnt_q);
	assign hi_ok  = ({1'b0, j, 1'b1} < cnt_q);

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		lw        = '0;
		ll        = 1'b0;
		tq_pop    = 1'b0;
		take_code = 1'b0;
		clr_blk   = 1'b0;
		set_pend  = 1'b0;
		clr_pend  = 1'b0;
		go_emit   = 1'b0;
		emit_hold = 1'b0;
		emit_last = 1'b0;
		widx_inc  = 1'b0;
		case (state_q)
			lzss_pkg::P_TAKE: begin
				if (tq_valid) begin
					if (pend_q) begin
						if (slot) begin
							load     = 1'b1;
							lw       = held_q;
							ll       = (tk.kind == lzss_pkg::TK_END);
							clr_pend = 1'b1;
							tq_pop   = (tk.kind == lzss_pkg::TK_END);
						end
					end else begin
						case (tk.kind)
							lzss_pkg::TK_HDR: begin
								if (slot) begin
									load   = 1'b1;
									lw     = {tk.data, lzss_pkg::HDR_TAG};
									tq_pop = 1'b1;
								end
							end
							lzss_pkg::TK_CODE: begin
								tq_pop    = 1'b1;
								take_code = 1'b1;
								if (cnt_q == 6'(BC - 1)) begin
									go_emit   = 1'b1;
									emit_hold = tk.final_step;
								end
							end
							lzss_pkg::TK_END: begin
								tq_pop = 1'b1;
								if (cnt_q != 6'd0) begin
									go_emit   = 1'b1;
									emit_last = 1'b1;
								end
							end
							default: begin
								tq_pop = 1'b1;
							end
						endcase
					end
				end
				if (go_emit) begin
					state_d = lzss_pkg::P_EMIT;
				end
			end
			lzss_pkg::P_EMIT: begin
				if ((widx_q == 5'(BW)) && hold_q) begin
					set_pend = 1'b1;
					state_d  = lzss_pkg::P_TAKE;
				end else if (slot) begin
					load = 1'b1;
					lw   = (widx_q == 5'd0) ? flag_q
					     : {hi_ok ? hi_q[j] : 16'h0000, lo_ok ? lo_q[j] : 16'h0000};
					ll   = (widx_q == 5'(BW)) && elast_q;
					if (widx_q == 5'(BW)) begin
						clr_blk = 1'b1;
						state_d = lzss_pkg::P_TAKE;
					end else begin
						widx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = lzss_pkg::P_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzss_pkg::P_TAKE;
			flag_q  <= '0;
			cnt_q   <= '0;
			widx_q  <= '0;
			hold_q  <= 1'b0;
			elast_q <= 1'b0;
			pend_q  <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_code) begin
				cnt_q <= cnt_q + 6'd1;
				if (tk.is_match) begin
					flag_q <= flag_q | (lzss_pkg::FLAG_TOP >> cnt_q[4:0]);
				end
			end
			if (go_emit) begin
				widx_q  <= '0;
				hold_q  <= emit_hold;
				elast_q <= emit_last;
			end
			if (widx_inc) begin
				widx_q <= widx_q + 5'd1;
			end
			if (set_pend) begin
				pend_q <= 1'b1;
			end
			if (clr_blk || clr_pend) begin
				cnt_q  <= '0;
				flag_q <= '0;
				pend_q <= 1'b0;
			end
			if (load) begin
				ovld_q <= 1'b1;
			end else if (pop) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_code) begin
			if (cnt_q[0]) begin
				hi_q[cnt_q[4:1]] <= tk.data[15:0];
			end else begin
				lo_q[cnt_q[4:1]] <= tk.data[15:0];
			end
		end
		if (set_pend) begin
			held_q <= {hi_q[j], lo_q[j]};
		end
		if (load) begin
			oword_q <= lw;
			olast_q <= ll;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(BC))
		else $error("code count beyond block size");

	a_pend_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (cnt_q == 6'(BC)))
		else $error("held word without a full block");

	a_emit_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lzss_pkg::P_EMIT) |-> !tq_pop)
		else $error("token taken while a block is being emitted");

endmodule

// ===== rtl/lzss_halfword_token_compressor.sv =====
// Top level of the LZSS halfword token compressor.
//
//   Channel   Handshake                Payload
//   ------    ---------------------    --------------------------------------
//   input     push / full              item   : data_byte, last_byte
//   result    empty / pop              result : out_word, last_word
//   config    cfg_valid / cfg_ready    cfg_data : total_length (24 bits)
//
// A byte request is taken while the front end is idle. When the lookahead
// holds a full MAX_MATCH bytes, or at the end mark for every remaining
// position, the position is coded: a position covered by an earlier match
// is skipped without a search, and a coded position runs a search of the
// whole window, in which the window RAM read port streams one byte per cycle
// past the 18-byte lookahead register while one candidate distance is
// compared each cycle.
// Reset needs no clearing pass: a written-byte count marks which window slots
// hold data of the current stream, and any other slot reads as 0xFF.
// The search front end and the block packer are joined by a four-entry token
// queue, and the packer drives a single result register, so a stalled result
// holds the packer only, and the front end keeps searching until the queue
// fills.
module lzss_halfword_token_compressor #(
	parameter int WINDOW_SIZE = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lzss_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output lzss_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [23:0]       cfg_data
);

	// Tokens carry the header request, each finished code, and the end of a stream.
	logic             fe_push;
	logic             fe_ready;
	lzss_pkg::token_t fe_tok;
	logic             tq_valid;
	logic             tq_pop;
	lzss_pkg::token_t tq_tok;

	// The front end owns the window RAM, the lookahead and the match search.
	lzss_front #(.WINDOW_SIZE(WINDOW_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.tok_push  (fe_push),
		.tok_ready (fe_ready),
		.tok       (fe_tok)
	);

	lzss_tq u_tq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.ready  (fe_ready),
		.din    (fe_tok),
		.valid  (tq_valid),
		.pop    (tq_pop),
		.dout   (tq_tok)
	);

	// The packer builds the flag word and code words of each 32-code block. A block
	// completed in the final step of a stream keeps its last word back until the
	// end token shows whether that word closes the stream.
	lzss_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.tq_valid (tq_valid),
		.tq_pop   (tq_pop),
		.tk       (tq_tok),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
